// ----- rtl/lfmc_pkg.sv -----
// shared codes, register defaults and types for the line follower motor controller
package lfmc_pkg;

  // control phase codes
  localparam logic [3:0] PH_DETECT     = 4'd0;
  localparam logic [3:0] PH_STRAIGHT   = 4'd1;
  localparam logic [3:0] PH_CORR_L     = 4'd2;
  localparam logic [3:0] PH_CORR_R     = 4'd3;
  localparam logic [3:0] PH_SEEK_CLEAR = 4'd4;
  localparam logic [3:0] PH_R_DELAY    = 4'd5;
  localparam logic [3:0] PH_R_WIDTH    = 4'd6;
  localparam logic [3:0] PH_R_SEEK     = 4'd7;
  localparam logic [3:0] PH_R_FINAL    = 4'd8;
  localparam logic [3:0] PH_L_HOLD     = 4'd9;
  localparam logic [3:0] PH_L_CHECK    = 4'd10;
  localparam logic [3:0] PH_L_SEEK     = 4'd11;

  // drive modes
  localparam logic [2:0] MODE_STOP     = 3'd0;
  localparam logic [2:0] MODE_STRAIGHT = 3'd1;
  localparam logic [2:0] MODE_CORR_L   = 3'd2;
  localparam logic [2:0] MODE_CORR_R   = 3'd3;
  localparam logic [2:0] MODE_TURN_L   = 3'd4;
  localparam logic [2:0] MODE_TURN_R   = 3'd5;

  // motor direction patterns, in1..in4 on bits 3..0
  localparam logic [3:0] DIR_STOP    = 4'b0000;
  localparam logic [3:0] DIR_FORWARD = 4'b1010;
  localparam logic [3:0] DIR_LEFT    = 4'b1001;
  localparam logic [3:0] DIR_RIGHT   = 4'b0110;

  // configuration register indexes
  localparam logic [2:0] REG_STRAIGHT_DUTY_LEFT  = 3'd0;
  localparam logic [2:0] REG_STRAIGHT_DUTY_RIGHT = 3'd1;
  localparam logic [2:0] REG_CORRECTION_DUTY     = 3'd2;
  localparam logic [2:0] REG_TURN_DUTY_LEFT      = 3'd3;
  localparam logic [2:0] REG_TURN_DUTY_RIGHT     = 3'd4;
  localparam logic [2:0] REG_ENTRY_DELAY_TICKS   = 3'd5;
  localparam logic [2:0] REG_WIDTH_DELAY_TICKS   = 3'd6;
  localparam logic [2:0] REG_CHECK_DELAY_TICKS   = 3'd7;

  localparam int DUTY_W  = 7;
  localparam int DELAY_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int PWM_PERIOD_DEFAULT = 100;

  // register reset values
  localparam logic [DUTY_W-1:0]  STRAIGHT_DUTY_LEFT_RST  = 7'd40;
  localparam logic [DUTY_W-1:0]  STRAIGHT_DUTY_RIGHT_RST = 7'd45;
  localparam logic [DUTY_W-1:0]  CORRECTION_DUTY_RST     = 7'd6;
  localparam logic [DUTY_W-1:0]  TURN_DUTY_LEFT_RST      = 7'd25;
  localparam logic [DUTY_W-1:0]  TURN_DUTY_RIGHT_RST     = 7'd30;
  localparam logic [DELAY_W-1:0] ENTRY_DELAY_TICKS_RST   = 16'd2464;
  localparam logic [DELAY_W-1:0] WIDTH_DELAY_TICKS_RST   = 16'd27000;
  localparam logic [DELAY_W-1:0] CHECK_DELAY_TICKS_RST   = 16'd500;

  // wait lengths handed to the sequencer
  typedef struct packed {
    logic [DELAY_W-1:0] entry_ticks;
    logic [DELAY_W-1:0] width_ticks;
    logic [DELAY_W-1:0] check_ticks;
  } delay_cfg_t;

  // decision after the current tick
  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] mode;
  } ctrl_state_t;

endpackage

// ----- rtl/line_follower_motor_controller.sv -----
// top level of the line follower motor controller: config, pwm and result register
//
//  channel   signals                                         direction
//  sensor    sensor_valid, sensor_stall, line_sensors        word in, one per timer tick
//  result    result_valid, result_stall, left_enable,        word out, one per sensor word
//            right_enable, direction_bits, control_phase
//  config    cfg_write, cfg_index, cfg_data                  register write, no read-back
//
//  one sensor word is taken per cycle while sensor_stall is low; its result word appears in
//  the output register the next cycle
//  the sequencer's next-state logic and the pwm compare sit between the sensor port and
//  the output register
//  reset (rst, synchronous) puts the sequencer in detect, sets the drive mode to stop, clears the
//  wait countdown and the pwm counter, and loads the register defaults
//  sensor_stall rises only while a result word is held and the result side stalls
module line_follower_motor_controller #(
  parameter int PWM_PERIOD = lfmc_pkg::PWM_PERIOD_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // sensor words
  input  logic                              sensor_valid,
  output logic                              sensor_stall,
  input  logic [4:0]                        line_sensors,
  // result words
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              left_enable,
  output logic                              right_enable,
  output logic [3:0]                        direction_bits,
  output logic [3:0]                        control_phase,
  // register writes
  input  logic                              cfg_write,
  input  logic [lfmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lfmc_pkg::*;

  // pwm counter holds 0..PWM_PERIOD, the incremented value reaches PWM_PERIOD+1
  localparam int PW = $clog2(PWM_PERIOD + 1);
  localparam int CW = PW + 1;
  localparam int CMP_W = (CW > DUTY_W) ? CW : DUTY_W;

  // configuration registers
  logic [DUTY_W-1:0]  straight_duty_left;
  logic [DUTY_W-1:0]  straight_duty_right;
  logic [DUTY_W-1:0]  correction_duty;
  logic [DUTY_W-1:0]  turn_duty_left;
  logic [DUTY_W-1:0]  turn_duty_right;
  logic [DELAY_W-1:0] entry_delay_ticks;
  logic [DELAY_W-1:0] width_delay_ticks;
  logic [DELAY_W-1:0] check_delay_ticks;

  logic               accept;
  delay_cfg_t         delays;
  ctrl_state_t        decision;

  logic [PW-1:0]      pwm_count;
  logic [PW-1:0]      pwm_count_next;
  logic [CW-1:0]      pwm_step;
  logic               pwm_wrap;

  logic [DUTY_W-1:0]  left_duty_sel;
  logic [DUTY_W-1:0]  right_duty_sel;
  logic [3:0]         dir_sel;
  logic               left_on;
  logic               right_on;

  // handshake: the output register frees up as it is taken, so words flow back to back
  assign sensor_stall = result_valid & result_stall;
  assign accept       = sensor_valid & ~sensor_stall;

  // register writes, data truncated to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      straight_duty_left  <= STRAIGHT_DUTY_LEFT_RST;
      straight_duty_right <= STRAIGHT_DUTY_RIGHT_RST;
      correction_duty     <= CORRECTION_DUTY_RST;
      turn_duty_left      <= TURN_DUTY_LEFT_RST;
      turn_duty_right     <= TURN_DUTY_RIGHT_RST;
      entry_delay_ticks   <= ENTRY_DELAY_TICKS_RST;
      width_delay_ticks   <= WIDTH_DELAY_TICKS_RST;
      check_delay_ticks   <= CHECK_DELAY_TICKS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STRAIGHT_DUTY_LEFT:  straight_duty_left  <= cfg_data[DUTY_W-1:0];
        REG_STRAIGHT_DUTY_RIGHT: straight_duty_right <= cfg_data[DUTY_W-1:0];
        REG_CORRECTION_DUTY:     correction_duty     <= cfg_data[DUTY_W-1:0];
        REG_TURN_DUTY_LEFT:      turn_duty_left      <= cfg_data[DUTY_W-1:0];
        REG_TURN_DUTY_RIGHT:     turn_duty_right     <= cfg_data[DUTY_W-1:0];
        REG_ENTRY_DELAY_TICKS:   entry_delay_ticks   <= cfg_data[DELAY_W-1:0];
        REG_WIDTH_DELAY_TICKS:   width_delay_ticks   <= cfg_data[DELAY_W-1:0];
        REG_CHECK_DELAY_TICKS:   check_delay_ticks   <= cfg_data[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign delays.entry_ticks = entry_delay_ticks;
  assign delays.width_ticks = width_delay_ticks;
  assign delays.check_ticks = check_delay_ticks;

  // phase sequencer, advances once per accepted sensor word
  lfmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .line_sensors (line_sensors),
    .delays       (delays),
    .decision     (decision)
  );

  // drive mode picks both duties and the bridge direction (mode after this tick)
  always_comb begin
    case (decision.mode)
      MODE_STRAIGHT: begin
        left_duty_sel  = straight_duty_left;
        right_duty_sel = straight_duty_right;
        dir_sel        = DIR_FORWARD;
      end
      MODE_CORR_L: begin
        left_duty_sel  = correction_duty;
        right_duty_sel = straight_duty_right;
        dir_sel        = DIR_FORWARD;
      end
      MODE_CORR_R: begin
        left_duty_sel  = straight_duty_left;
        right_duty_sel = correction_duty;
        dir_sel        = DIR_FORWARD;
      end
      MODE_TURN_L: begin
        left_duty_sel  = turn_duty_left;
        right_duty_sel = turn_duty_right;
        dir_sel        = DIR_LEFT;
      end
      MODE_TURN_R: begin
        left_duty_sel  = turn_duty_left;
        right_duty_sel = turn_duty_right;
        dir_sel        = DIR_RIGHT;
      end
      default: begin
        left_duty_sel  = '0;
        right_duty_sel = '0;
        dir_sel        = DIR_STOP;
      end
    endcase
  end

  // shared pwm counter: counts 0..PWM_PERIOD, both enables low on the wrap tick
  assign pwm_step       = CW'(pwm_count) + CW'(1);
  assign pwm_wrap       = (pwm_step > CW'(PWM_PERIOD));
  assign pwm_count_next = pwm_wrap ? '0 : pwm_step[PW-1:0];
  assign left_on        = ~pwm_wrap & (CMP_W'(pwm_step) <= CMP_W'(left_duty_sel));
  assign right_on       = ~pwm_wrap & (CMP_W'(pwm_step) <= CMP_W'(right_duty_sel));

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_count <= '0;
    end else if (accept) begin
      pwm_count <= pwm_count_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // result payload, loaded with every accepted word and held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      left_enable    <= left_on;
      right_enable   <= right_on;
      direction_bits <= dir_sel;
      control_phase  <= decision.phase;
    end
  end

endmodule

// ----- rtl/lfmc_ctrl.sv -----
// control sequencer: phase, drive mode and wait countdown
module lfmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [4:0]          line_sensors,
  input  lfmc_pkg::delay_cfg_t delays,
  output lfmc_pkg::ctrl_state_t decision
);
  import lfmc_pkg::*;

  logic [3:0]         phase;
  logic [3:0]         phase_next;
  logic [2:0]         mode;
  logic [2:0]         mode_next;
  logic [DELAY_W-1:0] delay_counter;
  logic [DELAY_W-1:0] delay_counter_next;

  logic l1, l2, m3, r4, r5;
  logic wait_done;
  logic edge_seen;

  // active low sensors
  assign l1 = ~line_sensors[0];
  assign l2 = ~line_sensors[1];
  assign m3 = ~line_sensors[2];
  assign r4 = ~line_sensors[3];
  assign r5 = ~line_sensors[4];

  assign wait_done = (delay_counter == '0);
  assign edge_seen = (phase == PH_CORR_L) ? l2 : r4;

  always_comb begin
    phase_next         = phase;
    mode_next          = mode;
    delay_counter_next = delay_counter;
    unique case (phase)
      PH_DETECT, PH_STRAIGHT: begin
        if (r5) begin
          mode_next          = MODE_STRAIGHT;
          delay_counter_next = delays.entry_ticks;
          phase_next         = PH_R_DELAY;
        end else if (l1) begin
          phase_next = PH_L_HOLD;
        end else if (l2) begin
          mode_next  = MODE_CORR_L;
          phase_next = PH_CORR_L;
        end else if (r4) begin
          mode_next  = MODE_CORR_R;
          phase_next = PH_CORR_R;
        end else if (!m3) begin
          mode_next  = MODE_TURN_R;
          phase_next = PH_SEEK_CLEAR;
        end else begin
          mode_next  = MODE_STRAIGHT;
          phase_next = PH_STRAIGHT;
        end
      end
      PH_CORR_L, PH_CORR_R: begin
        if (edge_seen) begin
          if (r5) begin
            mode_next          = MODE_STRAIGHT;
            delay_counter_next = delays.entry_ticks;
            phase_next         = PH_R_DELAY;
          end else if (l1) begin
            phase_next = PH_L_HOLD;
          end
        end else begin
          phase_next = PH_DETECT;
        end
      end
      PH_SEEK_CLEAR: begin
        mode_next = MODE_TURN_R;
        if (r4) begin
          if (m3) begin
            mode_next  = MODE_STRAIGHT;
            phase_next = PH_STRAIGHT;
          end else begin
            phase_next = PH_DETECT;
          end
        end
      end
      PH_R_DELAY: begin
        if (!wait_done) begin
          delay_counter_next = delay_counter - 1'b1;
        end else begin
          mode_next = MODE_TURN_R;
          if (m3) begin
            delay_counter_next = delays.width_ticks;
            phase_next         = PH_R_WIDTH;
          end else begin
            phase_next = PH_R_SEEK;
          end
        end
      end
      PH_R_WIDTH: begin
        if (!wait_done) begin
          delay_counter_next = delay_counter - 1'b1;
        end else if (m3) begin
          delay_counter_next = delays.width_ticks;
        end else begin
          phase_next = PH_R_FINAL;
        end
      end
      PH_R_SEEK: begin
        if (r4) begin
          if (r5) begin
            mode_next  = MODE_STRAIGHT;
            phase_next = PH_STRAIGHT;
          end else begin
            phase_next = PH_DETECT;
          end
        end
      end
      PH_R_FINAL: begin
        if (r4) begin
          phase_next = PH_DETECT;
        end
      end
      PH_L_HOLD: begin
        if (l1) begin
          if (r5) begin
            mode_next          = MODE_STRAIGHT;
            delay_counter_next = delays.entry_ticks;
            phase_next         = PH_R_DELAY;
          end
        end else begin
          delay_counter_next = delays.check_ticks;
          phase_next         = PH_L_CHECK;
        end
      end
      PH_L_CHECK: begin
        if (!wait_done) begin
          delay_counter_next = delay_counter - 1'b1;
        end else if (r5) begin
          mode_next          = MODE_STRAIGHT;
          delay_counter_next = delays.entry_ticks;
          phase_next         = PH_R_DELAY;
        end else if (m3 || l2 || r4) begin
          mode_next  = MODE_STRAIGHT;
          phase_next = PH_STRAIGHT;
        end else begin
          mode_next  = MODE_TURN_L;
          phase_next = PH_L_SEEK;
        end
      end
      PH_L_SEEK: begin
        mode_next = MODE_TURN_L;
        if (l2) begin
          if (l1) begin
            mode_next  = MODE_STRAIGHT;
            phase_next = PH_STRAIGHT;
          end else begin
            phase_next = PH_DETECT;
          end
        end
      end
      default: begin
        phase_next = PH_DETECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DETECT;
      mode          <= MODE_STOP;
      delay_counter <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      mode          <= mode_next;
      delay_counter <= delay_counter_next;
    end
  end

  assign decision.phase = phase_next;
  assign decision.mode  = mode_next;

endmodule
